### hw/rtl/assert_macros.svh
// Assertion helpers for the order book RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### hw/rtl/ptob_pkg.sv
package ptob_pkg;
   localparam int PRICE_W = 32;
   localparam int TIME_W  = 48;
   localparam int SYM_W   = 3;
   localparam int SIDE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int MASK_W  = 8;

   localparam logic [SIDE_W-1:0] SIDE_BUY  = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_SELL = 2'd2;

   localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TIME_W-1:0]  ptime;
   } entry_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic               ins;     // perform insert this cycle
      logic               is_bid;
      logic [PRICE_W-1:0] price;
      logic [TIME_W-1:0]  ptime;
   } bcast_type;
endpackage

### hw/rtl/ptob_cell.sv
// One book slot: compares against the new order and shifts in from its neighbor.
module ptob_cell (
   input  logic               clock,
   input  logic               ld,        // book select load
   input  ptob_pkg::entry_type ld_entry,
   input  logic               ld_valid,
   input  ptob_pkg::bcast_type bc,
   input  logic               prev_ahead, // left neighbor ranks ahead of new order
   input  logic               prev_valid,
   input  ptob_pkg::entry_type prev_entry,
   output logic               ahead,
   output logic               valid,
   output ptob_pkg::entry_type entry
);
   import ptob_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   always_comb begin
      if (!valid_ff) begin
         ahead = 1'b0;
      end else if (entry_ff.price != bc.price) begin
         ahead = bc.is_bid ? (entry_ff.price > bc.price) : (entry_ff.price < bc.price);
      end else begin
         ahead = entry_ff.ptime < bc.ptime;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ld) begin
         entry_in = ld_entry;
         valid_in = ld_valid;
      end else if (bc.ins && !ahead) begin
         if (prev_ahead) begin
            entry_in.price = bc.price;
            entry_in.ptime = bc.ptime;
            valid_in       = 1'b1;
         end else begin
            entry_in = prev_entry;
            valid_in = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      valid_ff <= valid_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;
endmodule

### hw/rtl/price_time_order_book_insert_core.sv
// Order book insert core. Each beat on req_ is one order; one rsp_ beat follows
// per order. A tracked order runs through the LOAD and INS states after accept:
// LOAD loads the selected symbol/side book from memory into the cell row, in INS
// the cells compare and shift in parallel, and the row is written back in the
// cycle after. The input stays closed until the response beat is taken, so an
// order in flight is finished before the next one is accepted. An ignored order
// answers in the cycle after accept. No clearing pass; book counts reset to empty.
module price_time_order_book_insert_core #(
   parameter int NUM_SYMBOLS = 8,
   parameter int BOOK_DEPTH  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // {priority_time[47:0], order_price[31:0], side[1:0], symbol_index[2:0]}, 85 bits of 88
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // {best_price[31:0], new_best, status[1:0]}, 40 bits with zero fill
   output logic [39:0]  rsp_tdata
);
   import ptob_pkg::*;
   `include "assert_macros.svh"

   localparam int NB    = 2 * NUM_SYMBOLS;
   localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
   localparam int CW    = $clog2(BOOK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_LOAD = 3'b010, S_INS = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [MASK_W-1:0] mask_ff;
   logic [SYM_W-1:0]  sym;
   logic [SIDE_W-1:0] side;
   logic [PRICE_W-1:0] price;
   logic [TIME_W-1:0]  ptime;
   assign sym   = req_tdata[2:0];
   assign side  = req_tdata[4:3];
   assign price = req_tdata[36:5];
   assign ptime = req_tdata[84:37];

   // one wide row per book, read and written at a single row address
   entry_type [BOOK_DEPTH-1:0] mem [NB];
   logic [CW-1:0] cnt_ff [NB];
   entry_type rd_row_ff [BOOK_DEPTH];

   bcast_type bc_ff;
   logic [BW-1:0] book_ff;
   logic [CW-1:0] n_ff;
   logic rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   logic acc, sym_ok, track;
   logic [BW-1:0] book_sel;
   assign acc    = req_tvalid && req_tready;
   assign sym_ok = (32'(sym) < NUM_SYMBOLS);
   assign track  = sym_ok && mask_ff[sym] && (side == SIDE_BUY || side == SIDE_SELL);
   assign book_sel = BW'({sym, side == SIDE_SELL});
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // cell row
   logic       ahead [BOOK_DEPTH];
   logic       cvalid [BOOK_DEPTH];
   entry_type  centry [BOOK_DEPTH];
   logic       ld;
   assign ld = (state_ff == S_LOAD);
   bcast_type bc;
   always_comb begin
      bc = bc_ff;
      bc.ins = (state_ff == S_INS);
   end

   for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      logic pa, pv;
      entry_type pe;
      if (g == 0) begin : g_head
         assign pa = 1'b1;
         assign pv = 1'b0;
         assign pe = '0;
      end else begin : g_body
         assign pa = ahead[g-1];
         assign pv = cvalid[g-1];
         assign pe = centry[g-1];
      end
      ptob_cell u_cell (
         .clock(clock), .ld(ld), .ld_entry(rd_row_ff[g]),
         .ld_valid(32'(g) < 32'(n_ff)), .bc(bc),
         .prev_ahead(pa), .prev_valid(pv), .prev_entry(pe),
         .ahead(ahead[g]), .valid(cvalid[g]), .entry(centry[g])
      );
   end

   logic head_new_best;
   assign head_new_best = !cvalid[0] ||
      (bc_ff.is_bid ? (bc_ff.price > centry[0].price) : (bc_ff.price < centry[0].price));

   // memory read of the whole row and book select
   always_ff @(posedge clock) begin
      if (acc) begin
         for (int i = 0; i < BOOK_DEPTH; i++) rd_row_ff[i] <= mem[book_sel][i];
      end
   end

   // row write-back the cycle after the insert
   logic wb_ff;
   always_ff @(posedge clock) begin
      if (wb_ff) begin
         for (int i = 0; i < BOOK_DEPTH; i++) mem[book_ff][i] <= centry[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (acc && track) state_in = S_LOAD;
         S_LOAD: state_in = S_INS;
         S_INS:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic [CW-1:0] n_next;
   assign n_next = (n_ff == CW'(BOOK_DEPTH)) ? n_ff : n_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= 8'hFF;
         rsp_valid_ff <= 1'b0;
         wb_ff        <= 1'b0;
         for (int i = 0; i < NB; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         wb_ff    <= (state_ff == S_INS);
         if (csr_we) mask_ff <= csr_wdata;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (acc && !track) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= '0;
         end
         if (state_ff == S_INS) begin
            cnt_ff[book_ff] <= n_next;
            rsp_valid_ff    <= 1'b1;
            rsp_data_ff     <= {5'd0,
               (ahead[0] ? centry[0].price : bc_ff.price),
               head_new_best,
               (n_ff == CW'(BOOK_DEPTH)) ? ST_FULL : ST_INSERTED};
         end
      end
   end

   // cell 0 updates at this same edge: head after insert is new order unless
   // old head ranks ahead.

   always_ff @(posedge clock) begin
      if (acc) begin
         book_ff      <= book_sel;
         n_ff         <= cnt_ff[book_sel];
         bc_ff.ins    <= 1'b0;
         bc_ff.is_bid <= (side == SIDE_BUY);
         bc_ff.price  <= price;
         bc_ff.ptime  <= ptime;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_no_acc_busy, clock, reset, state_ff != S_IDLE, !req_tready)
   `ASSERT_NEXT(a_load_to_ins, clock, reset, state_ff == S_LOAD, state_ff == S_INS)
   `ASSERT_NEXT(a_ins_rsp, clock, reset, state_ff == S_INS, rsp_valid_ff)
   `ASSERT_IMPLIES(a_cnt_bound, clock, reset, state_ff == S_INS, n_ff <= CW'(BOOK_DEPTH))
endmodule

### test/tb_price_time_order_book_insert_core.sv
module tb_price_time_order_book_insert_core;
   import ptob_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSYM  = 8;
   localparam int DEPTH = 16;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               new_best;
      logic [PRICE_W-1:0] best_price;
   } fill_type;

   class book_scoreboard;
      logic [MASK_W-1:0]  mask;
      logic [PRICE_W-1:0] prices[2][NSYM][DEPTH];
      logic [TIME_W-1:0]  times[2][NSYM][DEPTH];
      int                 counts[2][NSYM];
      fill_type           pending[$];
      int                 errors;

      function void clear();
         mask = '1;
         errors = 0;
         foreach (counts[b, s]) counts[b][s] = 0;
      endfunction

      function bit ahead(bit is_bid, logic [PRICE_W-1:0] p, logic [TIME_W-1:0] t,
                         logic [PRICE_W-1:0] np, logic [TIME_W-1:0] nt);
         if (p != np) return is_bid ? (p > np) : (p < np);
         return t < nt;
      endfunction

      // apply one order to the book copy and queue its expected beat
      function void note_order(logic [2:0] sym, logic [1:0] side,
                               logic [PRICE_W-1:0] price, logic [TIME_W-1:0] pt);
         fill_type f;
         int b, n, pos, i;
         bit is_bid;
         f = '0;
         if (mask[sym] && (side == SIDE_BUY || side == SIDE_SELL)) begin
            is_bid = (side == SIDE_BUY);
            b = is_bid ? 0 : 1;
            n = counts[b][sym];
            if (n == 0) f.new_best = 1;
            else if (is_bid ? price > prices[b][sym][0] : price < prices[b][sym][0])
               f.new_best = 1;
            pos = 0;
            while (pos < n && ahead(is_bid, prices[b][sym][pos], times[b][sym][pos],
                                    price, pt))
               pos++;
            f.status = (n == DEPTH) ? ST_FULL : ST_INSERTED;
            if (pos < DEPTH) begin
               i = (n < DEPTH) ? n : DEPTH - 1;
               while (i > pos) begin
                  prices[b][sym][i] = prices[b][sym][i-1];
                  times[b][sym][i] = times[b][sym][i-1];
                  i--;
               end
               prices[b][sym][pos] = price;
               times[b][sym][pos] = pt;
               if (n < DEPTH) n++;
            end
            counts[b][sym] = n;
            f.best_price = prices[b][sym][0];
         end
         pending.push_back(f);
      endfunction

      function void check_fill(logic [39:0] data);
         fill_type exp_f;
         logic [STAT_W-1:0]  st;
         logic               nb;
         logic [PRICE_W-1:0] bp;
         st = data[1:0];
         nb = data[2];
         bp = data[34:3];
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $realtime, data);
            errors++;
            return;
         end
         exp_f = pending.pop_front();
         if (st != exp_f.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_f.status, st);
            errors++;
         end
         if (nb != exp_f.new_best) begin
            $display("%0t: new_best expected %0d actual %0d", $realtime, exp_f.new_best, nb);
            errors++;
         end
         if (bp != exp_f.best_price) begin
            $display("%0t: best_price expected %h actual %h", $realtime,
                     exp_f.best_price, bp);
            errors++;
         end
         if (data[39:35] != 0) begin
            $display("%0t: fill bits expected 0 actual %h", $realtime, data[39:35]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [7:0]  csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   book_scoreboard sb;
   bit quiet = 0;       // no idling near the end
   bit hold_off = 0;    // long receiver stall requested
   logic [PRICE_W-1:0] near_price;

   price_time_order_book_insert_core #(.NUM_SYMBOLS(NSYM), .BOOK_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_order(logic [2:0] sym, logic [1:0] side,
                             logic [PRICE_W-1:0] price, logic [TIME_W-1:0] pt);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {pt, price, side, sym};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_order(sym, side, price, pt);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mask(logic [7:0] m);
      csr_we <= 1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 0;
      sb.mask = m;
   endtask

   // mostly tracked sides; prices clustered so equal prices and times occur
   task automatic random_order();
      logic [1:0] side;
      logic [PRICE_W-1:0] p;
      logic [TIME_W-1:0] t;
      side = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                         : ($urandom_range(0, 1) ? SIDE_BUY : SIDE_SELL);
      case ($urandom_range(0, 3))
         0: p = {$urandom};
         default: p = near_price + $urandom_range(0, 20);
      endcase
      if ($urandom_range(0, 2) == 0) t = TIME_W'($urandom_range(0, 15));
      else t = TIME_W'({$urandom, $urandom});
      send_order(3'($urandom_range(0, 7)), side, p, t);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      static int stall = 0;
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off) begin
         rsp_tready <= 0;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall = $urandom_range(0, 9);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_fill(rsp_tdata);
   end

   initial begin
      sb = new();
      sb.clear();
      near_price = 32'h8000_0000;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, both sides, ignored sides, equal price/time ties, full book
      send_order(0, SIDE_BUY, 0, 0);
      send_order(0, SIDE_BUY, '1, '1);
      send_order(0, SIDE_BUY, '1, '1);
      send_order(0, SIDE_BUY, '1, 0);
      send_order(7, SIDE_SELL, '1, '1);
      send_order(7, SIDE_SELL, 0, 0);
      send_order(7, SIDE_SELL, 0, 0);
      send_order(3, 2'd0, 5, 5);
      send_order(3, 2'd3, '1, '1);
      for (int i = 0; i < 17; i++) send_order(5, SIDE_BUY, 32'(100 + i), 48'(i));
      send_order(5, SIDE_BUY, 1, 0);
      drain();
      write_mask(8'h00);
      send_order(5, SIDE_BUY, 500, 0);
      send_order(2, SIDE_SELL, 1, 1);
      drain();
      write_mask(8'hA5);
      for (int i = 0; i < 8; i++) send_order(3'(i), SIDE_SELL, 32'(i), 48'(i));

      // random phases under several masks
      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < 250; k++) random_order();
         drain();
         write_mask((ph == 2) ? 8'hFF : 8'($urandom));
         near_price = {$urandom};
      end
      write_mask(8'hFF);

      // long stall: block must fill and push back on the input
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int k = 0; k < 60; k++) random_order();
      join

      quiet = 1;
      for (int k = 0; k < 60; k++) random_order();
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

### price_time_order_book_insert_core.f
+incdir+hw/rtl
hw/rtl/ptob_pkg.sv
hw/rtl/ptob_cell.sv
hw/rtl/price_time_order_book_insert_core.sv
test/tb_price_time_order_book_insert_core.sv
